// ===== design/assert_macros.svh =====
// assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent at the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/dwte_pkg.sv =====
// types and constants of the display write text encoder
`timescale 1ns / 1ps
package dwte_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic REG_DISPLAY_BASE = 1'b0;
  localparam logic REG_ROW_STRIDE   = 1'b1;

  localparam logic [15:0] DISPLAY_BASE_RST = 16'h4000;
  localparam logic [15:0] ROW_STRIDE_RST   = 16'h0020;

  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_DISPLAY = 1'b1;

  localparam logic [6:0] CH_BANG    = 7'h21;  // '!'
  localparam logic [6:0] CH_AMP     = 7'h26;  // '&'
  localparam logic [6:0] CH_EQ      = 7'h3D;  // '='
  localparam logic [6:0] CH_PCT     = 7'h25;  // '%'
  localparam logic [6:0] CH_DOLLAR  = 7'h24;  // '$'
  localparam logic [6:0] CH_NL      = 7'h0A;  // newline
  localparam logic [6:0] CH_ZERO    = 7'h30;  // '0'
  localparam logic [6:0] CH_LOWER_A = 7'h61;  // 'a'
  localparam logic [6:0] CH_UPPER_A = 7'h41;  // 'A'

  typedef enum logic [2:0] {
    MK_CMD,
    MK_BANG,
    MK_AMP,
    MK_EQ,
    MK_PCT,
    MK_DOLLAR
  } msg_kind_t;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [15:0] word_value;
  } in_word_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       last_char;
  } out_word_t;

  // classified message handed from front to back
  typedef struct packed {
    msg_kind_t   kind;
    logic [15:0] off;
    logic [15:0] data;
  } msg_t;

endpackage

// ===== design/dwte_front.sv =====
// front end: classifies each word and keeps the delta-coding state
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dwte_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  dwte_pkg::in_word_t in_word,
  input  logic [15:0]       display_base,
  input  logic [15:0]       row_stride,
  output dwte_pkg::msg_t    msg
);

  logic        first_r, first_nxt;
  logic [15:0] prev_data_r, prev_data_nxt;
  logic [15:0] prev_off_r, prev_off_nxt;

  logic [15:0] off;
  logic [16:0] next_off;
  logic [16:0] row_off;
  logic        is_next;
  logic        is_row;
  logic        disp_accept;

  assign off      = in_word.address - display_base;
  assign next_off = {1'b0, prev_off_r} + 17'd1;
  assign row_off  = {1'b0, prev_off_r} + {1'b0, row_stride};
  assign is_next  = ({1'b0, off} == next_off);
  assign is_row   = ({1'b0, off} == row_off);
  assign disp_accept = accept && (in_word.action == dwte_pkg::ACT_DISPLAY);

  always_comb begin
    msg.off       = off;
    msg.data      = in_word.word_value;
    msg.kind      = dwte_pkg::MK_BANG;
    first_nxt     = first_r;
    prev_data_nxt = prev_data_r;
    prev_off_nxt  = prev_off_r;
    if (in_word.action == dwte_pkg::ACT_COMMAND) begin
      msg.kind = dwte_pkg::MK_CMD;
    end else begin
      if (first_r || off == 16'd0) begin
        msg.kind = dwte_pkg::MK_BANG;
      end else if (in_word.word_value == prev_data_r) begin
        if (is_next) msg.kind = dwte_pkg::MK_AMP;
        else if (is_row) msg.kind = dwte_pkg::MK_EQ;
        else msg.kind = dwte_pkg::MK_PCT;
      end else if (is_next) begin
        msg.kind = dwte_pkg::MK_DOLLAR;
      end else begin
        msg.kind = dwte_pkg::MK_BANG;
      end
      if (accept) begin
        first_nxt    = 1'b0;
        prev_off_nxt = off;
        if (msg.kind == dwte_pkg::MK_BANG || msg.kind == dwte_pkg::MK_DOLLAR) begin
          prev_data_nxt = in_word.word_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      prev_data_r <= 16'd0;
      prev_off_r  <= 16'd0;
    end else begin
      first_r     <= first_nxt;
      prev_data_r <= prev_data_nxt;
      prev_off_r  <= prev_off_nxt;
    end
  end

  // a display write always leaves the first-write flag clear
  `ASSERT_NEXT(a_first_clears, clk, rst_n, disp_accept, !first_r)

endmodule

// ===== design/dwte_msgq.sv =====
// short message queue between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dwte_msgq #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dwte_pkg::msg_t push_msg,
  output logic           full,
  input  logic           pop,
  output dwte_pkg::msg_t head_msg,
  output logic           empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  dwte_pkg::msg_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic do_push, do_pop;

  assign full     = (count_r == DEPTH_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_msg = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_msg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= DEPTH_CNT)
  `ASSERT_NEXT(a_full_holds, clk, rst_n, full && !pop, full)

endmodule

// ===== design/dwte_back.sv =====
// back end: spells each message one character per cycle, unless held
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dwte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dwte_pkg::msg_t      head_msg,
  input  logic                q_empty,
  output logic                q_pop,
  output dwte_pkg::out_word_t out_word,
  output logic                empty,
  input  logic                pop
);

  logic           busy_r, busy_nxt;
  dwte_pkg::msg_t cur_r, cur_nxt;
  logic [3:0]     pos_r, pos_nxt;
  logic           ovalid_r, ovalid_nxt;
  dwte_pkg::out_word_t oword_r, oword_nxt;

  logic       advance;
  logic [6:0] ch;
  logic       is_last;
  logic       use_hex;
  logic       lower;
  logic [15:0] hex_src;
  logic [1:0] nib_idx;
  logic [3:0] nib;
  logic       short_msg;

  assign empty    = !ovalid_r;
  assign out_word = oword_r;
  assign advance  = busy_r && (!ovalid_r || pop);
  assign short_msg = (cur_r.kind == dwte_pkg::MK_AMP) || (cur_r.kind == dwte_pkg::MK_EQ);

  // character at the current position of the current message
  always_comb begin
    ch      = dwte_pkg::CH_NL;
    is_last = 1'b0;
    use_hex = 1'b0;
    lower   = 1'b0;
    hex_src = cur_r.data;
    nib_idx = 2'(4'd4 - pos_r);
    unique case (cur_r.kind) inside
      dwte_pkg::MK_CMD: begin
        lower   = 1'b1;
        nib_idx = 2'(4'd3 - pos_r);
        if (pos_r < 4'd4) use_hex = 1'b1;
        else is_last = 1'b1;
      end
      dwte_pkg::MK_BANG: begin
        if (pos_r == 4'd0) ch = dwte_pkg::CH_BANG;
        else if (pos_r < 4'd5) begin
          use_hex = 1'b1;
          hex_src = cur_r.off;
        end else if (pos_r < 4'd9) begin
          use_hex = 1'b1;
          nib_idx = 2'(4'd8 - pos_r);
        end else is_last = 1'b1;
      end
      dwte_pkg::MK_AMP, dwte_pkg::MK_EQ: begin
        if (pos_r == 4'd0) begin
          ch = (cur_r.kind == dwte_pkg::MK_AMP) ? dwte_pkg::CH_AMP : dwte_pkg::CH_EQ;
        end else is_last = 1'b1;
      end
      dwte_pkg::MK_PCT, dwte_pkg::MK_DOLLAR: begin
        if (cur_r.kind == dwte_pkg::MK_PCT) hex_src = cur_r.off;
        if (pos_r == 4'd0) begin
          ch = (cur_r.kind == dwte_pkg::MK_PCT) ? dwte_pkg::CH_PCT : dwte_pkg::CH_DOLLAR;
        end else if (pos_r < 4'd5) use_hex = 1'b1;
        else is_last = 1'b1;
      end
      default: is_last = 1'b1;
    endcase
    nib = hex_src[{nib_idx, 2'b00} +: 4];
    if (use_hex) begin
      if (nib <= 4'd9) ch = dwte_pkg::CH_ZERO + {3'd0, nib};
      else ch = {3'd0, nib} - 7'd10 + (lower ? dwte_pkg::CH_LOWER_A : dwte_pkg::CH_UPPER_A);
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    ovalid_nxt = ovalid_r && !pop;
    oword_nxt  = oword_r;
    q_pop      = 1'b0;
    if (advance) begin
      ovalid_nxt          = 1'b1;
      oword_nxt.char_out  = ch;
      oword_nxt.last_char = is_last;
      pos_nxt             = pos_r + 4'd1;
      if (is_last) busy_nxt = 1'b0;
    end
    // take the next message as soon as the current one is spelled out
    if ((!busy_r || (advance && is_last)) && !q_empty) begin
      q_pop    = 1'b1;
      busy_nxt = 1'b1;
      cur_nxt  = head_msg;
      pos_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      pos_r    <= 4'd0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    oword_r <= oword_nxt;
  end

  `ASSERT_ALWAYS(a_pos_bound, clk, rst_n, !busy_r || pos_r <= 4'd9)
  `ASSERT_ALWAYS(a_short_pos, clk, rst_n, !busy_r || !short_msg || pos_r <= 4'd1)

endmodule

// ===== design/display_write_text_encoder_top.sv =====
// top level of the display write text encoder
//
//   channel   direction  handshake               payload
//   input     in         push / full             in_word  (action, address, word_value)
//   result    out        empty / pop             out_word (char_out, last_char)
//   config    in/out     psel penable pwrite     paddr, pwdata, prdata, pready
//
// an accepted word is classified in the cycle it arrives and queued as a message
// the back end spells a message at one character per cycle while results are popped;
// a message is 2 to 10 characters long (command 5, '&' or '=' 2, '%' or '$' 6, '!' 10)
// input stalls only while the message queue is full; a held result can fill it
// reset is synchronous, active low; no clearing pass, block is ready the cycle after
`timescale 1ns / 1ps
module display_write_text_encoder_top #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input words
  input  logic                                 push,
  output logic                                 full,
  input  dwte_pkg::in_word_t                   in_word,
  // result words
  output logic                                 empty,
  input  logic                                 pop,
  output dwte_pkg::out_word_t                  out_word,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dwte_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [dwte_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [dwte_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  logic [15:0] base_r;
  logic [15:0] stride_r;
  logic        cfg_wr;

  logic           in_accept;
  dwte_pkg::msg_t front_msg;
  dwte_pkg::msg_t head_msg;
  logic           q_empty;
  logic           q_pop;

  // configuration registers, word address in paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= dwte_pkg::DISPLAY_BASE_RST;
      stride_r <= dwte_pkg::ROW_STRIDE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        dwte_pkg::REG_DISPLAY_BASE: base_r   <= pwdata[15:0];
        dwte_pkg::REG_ROW_STRIDE:   stride_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dwte_pkg::REG_DISPLAY_BASE: prdata = {16'd0, base_r};
      dwte_pkg::REG_ROW_STRIDE:   prdata = {16'd0, stride_r};
      default:                    prdata = '0;
    endcase
  end

  // a word is taken whenever the queue has room
  assign in_accept = push && !full;

  dwte_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .in_word      (in_word),
    .display_base (base_r),
    .row_stride   (stride_r),
    .msg          (front_msg)
  );

  // decouples classification from character output
  dwte_msgq #(
    .DEPTH (QDEPTH)
  ) u_msgq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_msg (front_msg),
    .full     (full),
    .pop      (q_pop),
    .head_msg (head_msg),
    .empty    (q_empty)
  );

  // serializer with its own output register
  dwte_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_msg (head_msg),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_word (out_word),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// ===== tb/display_write_text_encoder_checker.sv =====
// checker: watches the encoder channels, predicts each character and compares
`timescale 1ns / 1ps
module display_write_text_encoder_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic                                full,
  input  dwte_pkg::in_word_t                  in_word,
  input  logic                                empty,
  input  logic                                pop,
  input  dwte_pkg::out_word_t                 out_word,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dwte_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dwte_pkg::CFG_DATA_W-1:0]     pwdata,
  input  logic                                pready,
  output int                                  fail_count,
  output int                                  chars_owed
);

  logic [15:0] base_copy;
  logic [15:0] stride_copy;
  logic [15:0] last_data;
  logic [15:0] last_off;
  logic        no_write_yet;
  int          errors;
  dwte_pkg::out_word_t chars_due[$];

  function automatic logic [6:0] nib_ascii(logic [3:0] nib, logic [6:0] alpha);
    return (nib <= 4'd9) ? dwte_pkg::CH_ZERO + 7'(nib) : alpha + 7'(nib) - 7'd10;
  endfunction

  task automatic queue_char(logic [6:0] c, logic last);
    dwte_pkg::out_word_t ow;
    ow.char_out  = c;
    ow.last_char = last;
    chars_due.push_back(ow);
  endtask

  task automatic queue_hex(logic [15:0] v, logic [6:0] alpha);
    for (int i = 3; i >= 0; i--) queue_char(nib_ascii(v[i*4 +: 4], alpha), 1'b0);
  endtask

  // message for one word, with the delta coding of display writes
  task automatic spell_word(dwte_pkg::in_word_t w);
    logic [15:0] off;
    logic [16:0] next_off;
    logic [16:0] row_off;
    if (w.action == dwte_pkg::ACT_COMMAND) begin
      queue_hex(w.word_value, dwte_pkg::CH_LOWER_A);
    end else begin
      off      = w.address - base_copy;
      // exact sums, no wrap at 16 bits
      next_off = {1'b0, last_off} + 17'd1;
      row_off  = {1'b0, last_off} + {1'b0, stride_copy};
      if (no_write_yet || off == 16'd0) begin
        queue_char(dwte_pkg::CH_BANG, 1'b0);
        queue_hex(off, dwte_pkg::CH_UPPER_A);
        queue_hex(w.word_value, dwte_pkg::CH_UPPER_A);
        last_data    = w.word_value;
        no_write_yet = 1'b0;
      end else if (w.word_value == last_data) begin
        if ({1'b0, off} == next_off) begin
          queue_char(dwte_pkg::CH_AMP, 1'b0);
        end else if ({1'b0, off} == row_off) begin
          queue_char(dwte_pkg::CH_EQ, 1'b0);
        end else begin
          queue_char(dwte_pkg::CH_PCT, 1'b0);
          queue_hex(off, dwte_pkg::CH_UPPER_A);
        end
      end else if ({1'b0, off} == next_off) begin
        queue_char(dwte_pkg::CH_DOLLAR, 1'b0);
        queue_hex(w.word_value, dwte_pkg::CH_UPPER_A);
        last_data = w.word_value;
      end else begin
        queue_char(dwte_pkg::CH_BANG, 1'b0);
        queue_hex(off, dwte_pkg::CH_UPPER_A);
        queue_hex(w.word_value, dwte_pkg::CH_UPPER_A);
        last_data = w.word_value;
      end
      last_off = off;
    end
    queue_char(dwte_pkg::CH_NL, 1'b1);
  endtask

  always @(posedge clk) begin
    dwte_pkg::out_word_t want;
    if (!rst_n) begin
      chars_due.delete();
      base_copy    = dwte_pkg::DISPLAY_BASE_RST;
      stride_copy  = dwte_pkg::ROW_STRIDE_RST;
      last_data    = 16'd0;
      last_off     = 16'd0;
      no_write_yet = 1'b1;
      errors       = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == dwte_pkg::REG_ROW_STRIDE) stride_copy = pwdata[15:0];
        else base_copy = pwdata[15:0];
      end
      // a character leaving now belongs to an older word than one arriving now
      if (pop && !empty) begin
        if (chars_due.size() == 0) begin
          $error("unexpected word: char_out %h last_char %b",
                 out_word.char_out, out_word.last_char);
          errors++;
        end else begin
          want = chars_due.pop_front();
          if (out_word.char_out !== want.char_out) begin
            $error("char_out: expected %h, got %h", want.char_out, out_word.char_out);
            errors++;
          end
          if (out_word.last_char !== want.last_char) begin
            $error("last_char: expected %b, got %b", want.last_char, out_word.last_char);
            errors++;
          end
        end
      end
      if (push && !full) spell_word(in_word);
    end
    fail_count <= errors;
    chars_owed <= chars_due.size();
  end

endmodule

// ===== tb/tb_display_write_text_encoder_top.sv =====
// testbench top: stimulus, register writes and verdict for the text encoder
`timescale 1ns / 1ps
module tb_display_write_text_encoder_top;

  localparam int unsigned AW = dwte_pkg::CFG_ADDR_W;
  localparam int unsigned DW = dwte_pkg::CFG_DATA_W;

  // every input starts at a known value
  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  push    = 1'b0;
  dwte_pkg::in_word_t    in_word = '0;
  logic                  pop     = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [AW-1:0]         paddr   = '0;
  logic [DW-1:0]         pwdata  = '0;
  logic                  full;
  logic                  empty;
  dwte_pkg::out_word_t   out_word;
  logic [DW-1:0]         prdata;
  logic                  pready;
  int                    fail_count;
  int                    chars_owed;

  // idle odds in percent for each side, and a one-shot request for a long hold-off
  int          send_idle_pct = 0;
  int          take_idle_pct = 0;
  logic        hold_off_req  = 1'b0;
  // what the generator remembers of the last display write, to aim at each message kind
  logic [15:0] last_addr   = 16'h0000;
  logic [15:0] last_data   = 16'h0000;
  logic [15:0] base_now    = dwte_pkg::DISPLAY_BASE_RST;
  logic [15:0] stride_now  = dwte_pkg::ROW_STRIDE_RST;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  display_write_text_encoder_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .empty   (empty),
    .pop     (pop),
    .out_word(out_word),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  display_write_text_encoder_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fail_count(fail_count),
    .chars_owed(chars_owed)
  );

  // offer one word, with random idle cycles first; push stays high on return
  // so back-to-back words never drop it within a step
  task automatic send_word(input dwte_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk);
    // full sampled as it stood at the edge
    while (full) @(posedge clk);
  endtask

  // display write that also updates the generator's memory
  task automatic send_display(input logic [15:0] addr, input logic [15:0] data);
    dwte_pkg::in_word_t w;
    w.action     = dwte_pkg::ACT_DISPLAY;
    w.address    = addr;
    w.word_value = data;
    last_addr    = addr;
    last_data    = data;
    send_word(w);
  endtask

  // command words carry a random address, which the block must ignore
  task automatic send_command(input logic [15:0] value);
    dwte_pkg::in_word_t w;
    w.action     = dwte_pkg::ACT_COMMAND;
    w.address    = 16'($urandom);
    w.word_value = value;
    send_word(w);
  endtask

  // setup cycle, then access cycle; the register takes the value when pready is seen
  task automatic write_reg(input logic idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'({idx, 2'b00});
    pwdata  <= DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx == dwte_pkg::REG_ROW_STRIDE) stride_now = value;
    else base_now = value;
  endtask

  // drop push and wait until every expected character has come out
  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_data();
    logic [15:0] pool [4] = '{16'h0000, 16'hFFFF, 16'h2020, 16'h0741};
    if ($urandom_range(3) == 0) return pool[$urandom_range(3)];
    return 16'($urandom);
  endfunction

  // mostly well-formed delta sequences: next, row down, same data, new data,
  // plus commands, zero offsets and plain random writes as noise
  task automatic send_random_word;
    int r;
    r = $urandom_range(99);
    if (r < 15) send_command(16'($urandom));
    else if (r < 35) send_display(last_addr + 16'd1, last_data);
    else if (r < 50) send_display(last_addr + stride_now, last_data);
    else if (r < 60) send_display(16'($urandom), last_data);
    else if (r < 78) send_display(last_addr + 16'd1, pick_data());
    else if (r < 83) send_display(base_now, $urandom_range(1) ? last_data : pick_data());
    else send_display(16'($urandom), pick_data());
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) send_random_word();
  endtask

  // receiver: random pop each cycle, or a long hold-off counted here on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // hard stop if the block hangs
  initial begin
    #400000;
    $display("display_write_text_encoder_top regression: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset settings, written explicitly
    write_reg(dwte_pkg::REG_DISPLAY_BASE, dwte_pkg::DISPLAY_BASE_RST);
    write_reg(dwte_pkg::REG_ROW_STRIDE, dwte_pkg::ROW_STRIDE_RST);
    send_command(16'h0000);
    send_command(16'hFFFF);
    send_command(16'hA5C3);            // lowercase hex letters
    send_display(16'h4005, 16'h1234);  // first write
    send_display(16'h4006, 16'h1234);  // same data, next offset
    send_command(16'h0BEF);            // must not disturb the display state
    send_display(16'h4026, 16'h1234);  // same data, one row down
    send_display(16'h4100, 16'h1234);  // same data elsewhere
    send_display(16'h4101, 16'hABCD);  // new data, next offset
    send_display(16'h4300, 16'hFFFF);  // new data elsewhere
    send_display(16'h4000, 16'hFFFF);  // zero offset forces a full message
    send_display(16'h3FF0, 16'hFFFF);  // offset below base wraps to 0xfff0
    send_display(16'h4010, 16'hFFFF);  // row sum overflows 16 bits: no match
    send_display(16'h3FFF, 16'hFFFF);  // offset 0xffff
    send_display(16'h4000, 16'h0000);  // zero after 0xffff is not next
    drain;

    // stride of one: next wins over row
    write_reg(dwte_pkg::REG_DISPLAY_BASE, 16'h0000);
    write_reg(dwte_pkg::REG_ROW_STRIDE, 16'h0001);
    send_display(16'h0005, 16'h7777);
    send_display(16'h0006, 16'h7777);
    send_display(16'h0007, 16'h8888);
    drain;

    // zero stride: equal offset with same data counts as row down
    write_reg(dwte_pkg::REG_ROW_STRIDE, 16'h0000);
    send_display(16'h0007, 16'h8888);
    drain;

    // top extremes of both registers
    write_reg(dwte_pkg::REG_DISPLAY_BASE, 16'hFFFF);
    write_reg(dwte_pkg::REG_ROW_STRIDE, 16'hFFFF);
    send_display(16'h0000, 16'h0001);
    send_display(16'hFFFF, 16'h0001);
    send_display(16'hFFFE, 16'h0001);
    drain;

    // random, sender idles a little and receiver a lot
    write_reg(dwte_pkg::REG_DISPLAY_BASE, 16'($urandom));
    write_reg(dwte_pkg::REG_ROW_STRIDE, dwte_pkg::ROW_STRIDE_RST);
    send_idle_pct = 28;
    take_idle_pct = 72;
    random_phase(100);
    drain;

    // random, the other way round, with a random small stride
    write_reg(dwte_pkg::REG_DISPLAY_BASE, dwte_pkg::DISPLAY_BASE_RST);
    write_reg(dwte_pkg::REG_ROW_STRIDE, 16'($urandom_range(80, 1)));
    send_idle_pct = 72;
    take_idle_pct = 28;
    random_phase(100);
    drain;

    // no idling; receiver holds off long enough for the block to fill and stall input
    write_reg(dwte_pkg::REG_DISPLAY_BASE, 16'($urandom));
    write_reg(dwte_pkg::REG_ROW_STRIDE, 16'($urandom_range(65535, 1)));
    send_idle_pct = 0;
    take_idle_pct = 0;
    hold_off_req  = 1'b1;
    random_phase(100);
    drain;

    // a few more cycles to catch any stray character
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("display_write_text_encoder_top regression: pass");
    end else begin
      $display("display_write_text_encoder_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/dwte_pkg.sv
design/dwte_front.sv
design/dwte_msgq.sv
design/dwte_back.sv
design/display_write_text_encoder_top.sv
tb/display_write_text_encoder_checker.sv
tb/tb_display_write_text_encoder_top.sv
